@@ hdl/dhp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_pkg
// shared types and constants for the hamiltonian path check on a dag
// ----------------------------------------------------------------------------
package dhp_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VW = $clog2(MAX_VERTICES);        // vertex index width
  localparam int CW = $clog2(MAX_VERTICES + 1);    // counter width, holds the vertex count
  localparam int COUNT_W = 9;                      // vertex_count register width
  localparam int EP_W = 8;                         // edge endpoint field width
  localparam int QUEUE_DEPTH = 2;

  localparam logic MARK_GREY  = 1'b0;
  localparam logic MARK_BLACK = 1'b1;

  typedef enum logic [0:0] {
    CMD_EDGE   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_ROOT,
    ST_ROW_WAIT,
    ST_SCAN,
    ST_MARK_CHK,
    ST_POP_WAIT,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    cmd_t          cmd;
    logic          in_range;
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

@@ hdl/dhp_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/dhp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_front
// accepts input transfers, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module dhp_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic                     s_tuser,
  input  wire logic [2*dhp_pkg::EP_W-1:0] s_tdata,
  output logic                          item_valid,
  output dhp_pkg::work_item_t           item,
  input  wire logic                     item_pop,
  output dhp_pkg::queue_status_t        status
);

  dhp_pkg::work_item_t q_mem [dhp_pkg::QUEUE_DEPTH];
  logic                wptr;
  logic                rptr;
  logic [1:0]          count;
  dhp_pkg::work_item_t incoming;
  logic [dhp_pkg::EP_W-1:0] src_f;
  logic [dhp_pkg::EP_W-1:0] dst_f;
  logic                push;

  assign src_f = s_tdata[dhp_pkg::EP_W-1:0];
  assign dst_f = s_tdata[2*dhp_pkg::EP_W-1:dhp_pkg::EP_W];

  // endpoints beyond the matrix make the edge a no-op
  always_comb begin
    incoming.cmd      = dhp_pkg::cmd_t'(s_tuser);
    incoming.in_range = (32'(src_f) < dhp_pkg::MAX_VERTICES) &&
                        (32'(dst_f) < dhp_pkg::MAX_VERTICES);
    incoming.src      = dhp_pkg::VW'(src_f);
    incoming.dst      = dhp_pkg::VW'(dst_f);
  end

  assign status.full  = (count == 2'(dhp_pkg::QUEUE_DEPTH));
  assign status.empty = (count == 2'd0);
  assign s_tready     = !status.full;
  assign push         = s_tvalid && s_tready;
  assign item_valid   = !status.empty;
  assign item         = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (item_pop) begin
        rptr <= !rptr;
      end
      case ({push, item_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dhp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_back
// edge loading and depth-first topological walk over the adjacency matrix
// ----------------------------------------------------------------------------
module dhp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dhp_pkg::COUNT_W-1:0] vertex_count,
  input  wire logic                        item_valid,
  input  dhp_pkg::work_item_t              item,
  output logic                             item_pop,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic                             res_has_path,
  output logic                             res_cycle
);

  localparam int VW = dhp_pkg::VW;
  localparam int CW = dhp_pkg::CW;
  localparam int NV = dhp_pkg::MAX_VERTICES;
  localparam int SW = VW + CW;

  dhp_pkg::back_state_t state, state_next;

  logic [CW-1:0] root;
  logic [VW-1:0] top_u;
  logic [CW-1:0] top_j;
  logic [CW-1:0] depth;
  logic [NV-1:0] row;
  logic [VW-1:0] prev;
  logic          has_prev;
  logic          path_ok;
  logic          cycle;
  logic [CW-1:0] limit;
  logic [VW-1:0] edge_src;
  logic [VW-1:0] edge_dst;
  logic [NV-1:0] visited;
  logic [NV-1:0] row_valid;

  logic          adj_we;
  logic [VW-1:0] adj_waddr;
  logic [NV-1:0] adj_wdata;
  logic [VW-1:0] adj_raddr;
  logic [NV-1:0] adj_rdata;
  logic          mark_we;
  logic [VW-1:0] mark_waddr;
  logic          mark_wdata;
  logic          mark_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata;
  logic [VW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;

  logic [CW-1:0] lim_calc;
  logic [VW-1:0] j_idx;
  logic [VW-1:0] root_idx;
  logic          scan_end;
  logic          root_end;
  logic [VW-1:0] stk_u;
  logic [CW-1:0] stk_next;
  logic [NV-1:0] dst_bit;
  logic [CW-1:0] depth_m1;
  logic [CW-1:0] depth_m2;

  dhp_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  dhp_ram #(.WIDTH(1), .DEPTH(NV)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(j_idx), .rdata(mark_rdata)
  );

  dhp_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_comb begin
    lim_calc = (32'(vertex_count) > NV) ? CW'(NV) : CW'(vertex_count);
    j_idx    = top_j[VW-1:0];
    root_idx = root[VW-1:0];
    scan_end = (top_j >= limit);
    root_end = (root >= limit);
    stk_u    = stk_rdata[SW-1:CW];
    stk_next = stk_rdata[CW-1:0];
    depth_m1 = depth - CW'(1);
    depth_m2 = depth - CW'(2);
    dst_bit  = '0;
    dst_bit[edge_dst] = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dhp_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.cmd == dhp_pkg::CMD_FINISH) begin
            state_next = dhp_pkg::ST_ROOT;
          end else if (item.in_range) begin
            state_next = dhp_pkg::ST_EDGE_WR;
          end
        end
      end
      dhp_pkg::ST_EDGE_WR: state_next = dhp_pkg::ST_IDLE;
      dhp_pkg::ST_ROOT: begin
        if (root_end) begin
          state_next = dhp_pkg::ST_DONE;
        end else if (!visited[root_idx]) begin
          state_next = dhp_pkg::ST_ROW_WAIT;
        end
      end
      dhp_pkg::ST_ROW_WAIT: state_next = dhp_pkg::ST_SCAN;
      dhp_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = (depth == CW'(1)) ? dhp_pkg::ST_ROOT : dhp_pkg::ST_POP_WAIT;
        end else if (row[j_idx]) begin
          state_next = dhp_pkg::ST_MARK_CHK;
        end
      end
      dhp_pkg::ST_MARK_CHK: begin
        if (!visited[j_idx]) begin
          state_next = dhp_pkg::ST_ROW_WAIT;
        end else if (mark_rdata == dhp_pkg::MARK_GREY) begin
          state_next = dhp_pkg::ST_DONE;
        end else begin
          state_next = dhp_pkg::ST_SCAN;
        end
      end
      dhp_pkg::ST_POP_WAIT: state_next = dhp_pkg::ST_ROW_WAIT;
      dhp_pkg::ST_DONE: begin
        if (!res_valid) begin
          state_next = dhp_pkg::ST_IDLE;
        end
      end
      default: state_next = dhp_pkg::ST_IDLE;
    endcase
  end

  // memory ports and queue pop
  always_comb begin
    item_pop   = 1'b0;
    adj_we     = 1'b0;
    adj_waddr  = edge_src;
    adj_wdata  = (row_valid[edge_src] ? adj_rdata : '0) | dst_bit;
    adj_raddr  = top_u;
    mark_we    = 1'b0;
    mark_waddr = top_u;
    mark_wdata = dhp_pkg::MARK_GREY;
    stk_we     = 1'b0;
    stk_waddr  = depth_m1[VW-1:0];
    stk_wdata  = {top_u, top_j + CW'(1)};
    stk_raddr  = depth_m2[VW-1:0];
    unique case (state)
      dhp_pkg::ST_IDLE: begin
        item_pop  = item_valid;
        adj_raddr = item.src;
      end
      dhp_pkg::ST_EDGE_WR: adj_we = 1'b1;
      dhp_pkg::ST_ROOT: begin
        adj_raddr  = root_idx;
        mark_waddr = root_idx;
        mark_we    = !root_end && !visited[root_idx];
      end
      dhp_pkg::ST_SCAN: begin
        mark_we    = scan_end;
        mark_wdata = dhp_pkg::MARK_BLACK;
      end
      dhp_pkg::ST_MARK_CHK: begin
        adj_raddr  = j_idx;
        mark_waddr = j_idx;
        mark_we    = !visited[j_idx];
        stk_we     = !visited[j_idx];
      end
      dhp_pkg::ST_POP_WAIT: adj_raddr = stk_u;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dhp_pkg::ST_IDLE;
      visited   <= '0;
      row_valid <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        dhp_pkg::ST_IDLE: begin
          if (item_valid) begin
            edge_src <= item.src;
            edge_dst <= item.dst;
            limit    <= lim_calc;
            root     <= '0;
            path_ok  <= 1'b1;
            has_prev <= 1'b0;
            cycle    <= 1'b0;
          end
        end
        dhp_pkg::ST_EDGE_WR: row_valid[edge_src] <= 1'b1;
        dhp_pkg::ST_ROOT: begin
          if (!root_end) begin
            root <= root + CW'(1);
            if (!visited[root_idx]) begin
              visited[root_idx] <= 1'b1;
              top_u <= root_idx;
              top_j <= '0;
              depth <= CW'(1);
            end
          end
        end
        dhp_pkg::ST_ROW_WAIT: row <= row_valid[top_u] ? adj_rdata : '0;
        dhp_pkg::ST_SCAN: begin
          if (scan_end) begin
            // order check: each finished vertex must reach the one before it
            if (has_prev && !row[prev]) begin
              path_ok <= 1'b0;
            end
            prev     <= top_u;
            has_prev <= 1'b1;
            depth    <= depth_m1;
          end else if (!row[j_idx]) begin
            top_j <= top_j + CW'(1);
          end
        end
        dhp_pkg::ST_MARK_CHK: begin
          if (!visited[j_idx]) begin
            visited[j_idx] <= 1'b1;
            top_u <= j_idx;
            top_j <= '0;
            depth <= depth + CW'(1);
          end else if (mark_rdata == dhp_pkg::MARK_GREY) begin
            cycle <= 1'b1;
          end else begin
            top_j <= top_j + CW'(1);
          end
        end
        dhp_pkg::ST_POP_WAIT: begin
          top_u <= stk_u;
          top_j <= stk_next;
        end
        dhp_pkg::ST_DONE: begin
          if (!res_valid) begin
            res_valid    <= 1'b1;
            res_has_path <= path_ok && !cycle;
            res_cycle    <= cycle;
            visited      <= '0;
            row_valid    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dag_hamiltonian_path_check_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dag_hamiltonian_path_check_top
// hamiltonian path check on a dag via depth-first topological sort
// ----------------------------------------------------------------------------
// edge transfer: accepted into a two entry queue; the engine reads the adjacency
//   row of the source, then writes the row back with the target bit set
// finish transfer: each visited vertex gets an entry step, a row read wait and a
//   scan over its row, each edge met a mark check, each return to a parent a
//   stack pop and a row read wait; the walk ends in its one result
// reset: synchronous, clears queue, marks, matrix row valid bits and output
// ----------------------------------------------------------------------------
module dag_hamiltonian_path_check_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,     // vertex_count
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tuser,       // command
  input  wire logic [15:0] s_tdata,       // edge_source [7:0], edge_target [15:8]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata        // has_path [0], cycle_found [1], zero fill
);

  logic [dhp_pkg::COUNT_W-1:0] vertex_count;
  logic                        item_valid;
  dhp_pkg::work_item_t         item;
  logic                        item_pop;
  dhp_pkg::queue_status_t      q_status;
  logic                        res_has_path;
  logic                        res_cycle;

  // vertex count register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dhp_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // front: transfer accept, edge range check, queue
  dhp_front u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .item_valid(item_valid),
    .item(item),
    .item_pop(item_pop),
    .status(q_status)
  );

  // back: matrix loading, walk, order check, result register
  dhp_back u_back (
    .clk(clk),
    .rst(rst),
    .vertex_count(vertex_count),
    .item_valid(item_valid),
    .item(item),
    .item_pop(item_pop),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res_has_path(res_has_path),
    .res_cycle(res_cycle)
  );

  assign m_tdata = {6'd0, res_cycle, res_has_path};

  // a cycle always forces a negative answer
  a_cycle_no_path : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("cycle flagged together with a path");

  // queue full blocks new transfers
  a_full_blocks : assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !s_tready)
    else $error("input ready while queue full");

  // queue never pops while empty
  a_no_empty_pop : assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !item_pop)
    else $error("engine popped an empty queue");

  // reset leaves no result pending
  a_reset_clear : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
